### design/mpct_pkg.sv
// Shared types and constants for the mouse packet cursor tracker.
// No dependencies; used by mpct_cursor_step and mouse_packet_cursor_tracker_core.
package mpct_pkg;

    // Width of every configuration register and of the cursor result fields.
    localparam int REG_BITS = 10;
    localparam int REG_COUNT = 8;
    localparam int REG_ADDR_BITS = 3;
    localparam int ICON_COUNT = 3;

    // Acknowledge byte that the mouse returns to commands.
    localparam logic [7:0] ACK_CODE = 8'hFA;

    // Bit positions inside the status byte.
    localparam int STAT_LEFT_BIT = 0;
    localparam int STAT_XSIGN_BIT = 4;
    localparam int STAT_YSIGN_BIT = 5;

    // Icon result code when nothing is clicked.
    localparam logic [1:0] ICON_NONE = 2'd3;

    // Register reset values.
    localparam logic [REG_BITS-1:0] X_MAX_RESET = 10'd304;
    localparam logic [REG_BITS-1:0] Y_MAX_RESET = 10'd191;

    // Configuration register indexes.
    typedef enum logic [REG_ADDR_BITS-1:0] {
        REG_X_MAX   = 3'd0,
        REG_Y_MAX   = 3'd1,
        REG_ICON0_X = 3'd2,
        REG_ICON0_Y = 3'd3,
        REG_ICON1_X = 3'd4,
        REG_ICON1_Y = 3'd5,
        REG_ICON2_X = 3'd6,
        REG_ICON2_Y = 3'd7
    } reg_index_t;

    // Packet byte phase, one-hot.
    typedef enum logic [2:0] {
        PH_STATUS = 3'b001,
        PH_XDATA  = 3'b010,
        PH_YDATA  = 3'b100
    } phase_t;

    typedef logic [REG_BITS-1:0] reg_word_t;

endpackage

### design/mpct_cursor_step.sv
// Cursor update for one complete packet: delta sign extension, add and clamp,
// motion detect and icon hit test. Pure combinational; depends on mpct_pkg.
module mpct_cursor_step #(
    parameter int COORD_BITS = 10,
    parameter int ICON_W = 32,
    parameter int ICON_H = 32
) (
    input  logic [COORD_BITS-1:0] pos_x,
    input  logic [COORD_BITS-1:0] pos_y,
    input  logic [7:0]            status_byte,
    input  logic [7:0]            x_byte,
    input  logic [7:0]            y_byte,
    input  mpct_pkg::reg_word_t   x_max,
    input  mpct_pkg::reg_word_t   y_max,
    input  mpct_pkg::reg_word_t   icon_x [mpct_pkg::ICON_COUNT],
    input  mpct_pkg::reg_word_t   icon_y [mpct_pkg::ICON_COUNT],
    output logic [COORD_BITS-1:0] new_x,
    output logic [COORD_BITS-1:0] new_y,
    output logic                  moved,
    output logic [1:0]            icon_hit
);

    // Working width: covers the coordinate or register range plus sign and carry.
    localparam int BASE_BITS =
        (COORD_BITS > mpct_pkg::REG_BITS) ? COORD_BITS : mpct_pkg::REG_BITS;
    localparam int SW = BASE_BITS + 2;
    localparam logic [SW-1:0] COORD_CAP = SW'((64'd1 << COORD_BITS) - 64'd1);
    localparam logic [SW-1:0] ICON_W_EXT = SW'(ICON_W);
    localparam logic [SW-1:0] ICON_H_EXT = SW'(ICON_H);

    logic signed [SW-1:0] dx;
    logic signed [SW-1:0] dy;
    logic signed [SW-1:0] sum_x;
    logic signed [SW-1:0] sum_y;
    logic [SW-1:0]        lim_x;
    logic [SW-1:0]        lim_y;
    logic [SW-1:0]        cfg_x_ext;
    logic [SW-1:0]        cfg_y_ext;
    logic [SW-1:0]        nx_ext;
    logic [SW-1:0]        ny_ext;
    logic [SW-1:0]        ix_ext;
    logic [SW-1:0]        iy_ext;
    logic                 hit_found;
    logic                 left;

    // Sign-extend the 9-bit deltas using the sign bits of the status byte.
    assign dx = $signed({{(SW-8){status_byte[mpct_pkg::STAT_XSIGN_BIT]}}, x_byte});
    assign dy = $signed({{(SW-8){status_byte[mpct_pkg::STAT_YSIGN_BIT]}}, y_byte});

    // X moves right with a positive delta; screen Y grows downward.
    assign sum_x = $signed({{(SW-COORD_BITS){1'b0}}, pos_x}) + dx;
    assign sum_y = $signed({{(SW-COORD_BITS){1'b0}}, pos_y}) - dy;

    // The limit is the configured max, capped at the coordinate range.
    assign cfg_x_ext = {{(SW-mpct_pkg::REG_BITS){1'b0}}, x_max};
    assign cfg_y_ext = {{(SW-mpct_pkg::REG_BITS){1'b0}}, y_max};
    assign lim_x = (cfg_x_ext < COORD_CAP) ? cfg_x_ext : COORD_CAP;
    assign lim_y = (cfg_y_ext < COORD_CAP) ? cfg_y_ext : COORD_CAP;

    // Clamp each coordinate to the range from zero to its limit.
    always_comb begin
        if (sum_x[SW-1]) begin
            new_x = '0;
        end else if ($unsigned(sum_x) >= lim_x) begin
            new_x = lim_x[COORD_BITS-1:0];
        end else begin
            new_x = sum_x[COORD_BITS-1:0];
        end
        if (sum_y[SW-1]) begin
            new_y = '0;
        end else if ($unsigned(sum_y) >= lim_y) begin
            new_y = lim_y[COORD_BITS-1:0];
        end else begin
            new_y = sum_y[COORD_BITS-1:0];
        end
    end

    assign moved = (new_x != pos_x) || (new_y != pos_y);
    assign left = status_byte[mpct_pkg::STAT_LEFT_BIT];

    // Left down: lowest-numbered icon holding the new cursor wins; full-width compares.
    assign nx_ext = {{(SW-COORD_BITS){1'b0}}, new_x};
    assign ny_ext = {{(SW-COORD_BITS){1'b0}}, new_y};

    always_comb begin
        icon_hit = mpct_pkg::ICON_NONE;
        hit_found = 1'b0;
        ix_ext = '0;
        iy_ext = '0;
        for (int k = 0; k < mpct_pkg::ICON_COUNT; k++) begin
            ix_ext = {{(SW-mpct_pkg::REG_BITS){1'b0}}, icon_x[k]};
            iy_ext = {{(SW-mpct_pkg::REG_BITS){1'b0}}, icon_y[k]};
            if (left && !hit_found &&
                nx_ext >= ix_ext && nx_ext < ix_ext + ICON_W_EXT &&
                ny_ext >= iy_ext && ny_ext < iy_ext + ICON_H_EXT) begin
                icon_hit = 2'(k);
                hit_found = 1'b1;
            end
        end
    end

endmodule

### design/mouse_packet_cursor_tracker_core.sv
// Top level of the mouse packet cursor tracker: input register, packet state,
// configuration registers and result register. Depends on mpct_pkg and mpct_cursor_step.

// Takes PS/2 mouse bytes on the s_ channel and gives one result transfer on the m_
// channel for every completed three-byte packet; an acknowledge byte (0xFA) where a
// packet should start is dropped. Each byte is held in the input register and the
// packet math then runs combinationally into the result register, so the block
// accepts one byte per cycle except while a byte that completes a packet waits; it
// waits in the input register only while the result register still holds an
// untaken result. Configuration registers are written through cfg_we/cfg_addr/cfg_wdata
// and must only be changed while the block is idle.
module mouse_packet_cursor_tracker_core #(
    parameter int COORD_BITS = 10,
    parameter int ICON_W = 32,
    parameter int ICON_H = 32
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // Configuration write port.
    input  logic                                 cfg_we,
    input  logic [mpct_pkg::REG_ADDR_BITS-1:0]   cfg_addr,
    input  logic [mpct_pkg::REG_BITS-1:0]        cfg_wdata,
    // Byte input channel.
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [7:0]                           s_rx_byte,
    // Result channel.
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [mpct_pkg::REG_BITS-1:0]        m_cursor_x,
    output logic [mpct_pkg::REG_BITS-1:0]        m_cursor_y,
    output logic                                 m_moved,
    output logic                                 m_left_button,
    output logic [1:0]                           m_icon_hit
);

    mpct_pkg::reg_word_t x_max_reg;
    mpct_pkg::reg_word_t y_max_reg;
    mpct_pkg::reg_word_t icon_x_reg [mpct_pkg::ICON_COUNT];
    mpct_pkg::reg_word_t icon_y_reg [mpct_pkg::ICON_COUNT];

    logic                  in_valid_reg;
    logic [7:0]            in_byte_reg;
    mpct_pkg::phase_t      phase_reg;
    mpct_pkg::phase_t      phase_next;
    logic [7:0]            status_reg;
    logic [7:0]            xbyte_reg;
    logic [COORD_BITS-1:0] pos_x_reg;
    logic [COORD_BITS-1:0] pos_y_reg;

    logic                  out_valid_reg;
    mpct_pkg::reg_word_t   out_x_reg;
    mpct_pkg::reg_word_t   out_y_reg;
    logic                  out_moved_reg;
    logic                  out_left_reg;
    logic [1:0]            out_hit_reg;

    logic                  is_final_byte;
    logic                  out_free;
    logic                  step_fire;
    logic                  packet_done;
    logic [COORD_BITS-1:0] new_x;
    logic [COORD_BITS-1:0] new_y;
    logic                  new_moved;
    logic [1:0]            new_hit;

    // Configuration registers; indexes beyond the list do not exist at this width.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_max_reg <= mpct_pkg::X_MAX_RESET;
            y_max_reg <= mpct_pkg::Y_MAX_RESET;
            for (int k = 0; k < mpct_pkg::ICON_COUNT; k++) begin
                icon_x_reg[k] <= '0;
                icon_y_reg[k] <= '0;
            end
        end else if (cfg_we) begin
            unique case (mpct_pkg::reg_index_t'(cfg_addr))
                mpct_pkg::REG_X_MAX:   x_max_reg <= cfg_wdata;
                mpct_pkg::REG_Y_MAX:   y_max_reg <= cfg_wdata;
                mpct_pkg::REG_ICON0_X: icon_x_reg[0] <= cfg_wdata;
                mpct_pkg::REG_ICON0_Y: icon_y_reg[0] <= cfg_wdata;
                mpct_pkg::REG_ICON1_X: icon_x_reg[1] <= cfg_wdata;
                mpct_pkg::REG_ICON1_Y: icon_y_reg[1] <= cfg_wdata;
                mpct_pkg::REG_ICON2_X: icon_x_reg[2] <= cfg_wdata;
                mpct_pkg::REG_ICON2_Y: icon_y_reg[2] <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Handshake: the held byte moves on unless it completes a packet and the
    // result register is still occupied.
    assign is_final_byte = (phase_reg == mpct_pkg::PH_YDATA);
    assign out_free      = !out_valid_reg || m_ready;
    assign step_fire     = in_valid_reg && (!is_final_byte || out_free);
    assign packet_done   = step_fire && is_final_byte;
    assign s_ready       = !in_valid_reg || step_fire;

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_byte_reg <= s_rx_byte;
        end
    end

    // Packet phase: an acknowledge byte at packet start keeps the phase.
    always_comb begin
        unique case (phase_reg)
            mpct_pkg::PH_XDATA: phase_next = mpct_pkg::PH_YDATA;
            mpct_pkg::PH_YDATA: phase_next = mpct_pkg::PH_STATUS;
            default: begin
                phase_next = (in_byte_reg == mpct_pkg::ACK_CODE) ? mpct_pkg::PH_STATUS
                                                                 : mpct_pkg::PH_XDATA;
            end
        endcase
    end

    // Packet state and cursor position.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= mpct_pkg::PH_STATUS;
            status_reg <= '0;
            xbyte_reg  <= '0;
            pos_x_reg  <= '0;
            pos_y_reg  <= '0;
        end else if (step_fire) begin
            phase_reg <= phase_next;
            if (phase_reg == mpct_pkg::PH_XDATA) begin
                xbyte_reg <= in_byte_reg;
            end else if (is_final_byte) begin
                pos_x_reg <= new_x;
                pos_y_reg <= new_y;
            end else if (in_byte_reg != mpct_pkg::ACK_CODE) begin
                status_reg <= in_byte_reg;
            end
        end
    end

    mpct_cursor_step #(
        .COORD_BITS (COORD_BITS),
        .ICON_W     (ICON_W),
        .ICON_H     (ICON_H)
    ) u_step (
        .pos_x       (pos_x_reg),
        .pos_y       (pos_y_reg),
        .status_byte (status_reg),
        .x_byte      (xbyte_reg),
        .y_byte      (in_byte_reg),
        .x_max       (x_max_reg),
        .y_max       (y_max_reg),
        .icon_x      (icon_x_reg),
        .icon_y      (icon_y_reg),
        .new_x       (new_x),
        .new_y       (new_y),
        .moved       (new_moved),
        .icon_hit    (new_hit)
    );

    // Result register: filled when a packet completes, emptied by an output transfer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (packet_done) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (packet_done) begin
            out_x_reg     <= mpct_pkg::REG_BITS'(new_x);
            out_y_reg     <= mpct_pkg::REG_BITS'(new_y);
            out_moved_reg <= new_moved;
            out_left_reg  <= status_reg[mpct_pkg::STAT_LEFT_BIT];
            out_hit_reg   <= new_hit;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_cursor_x    = out_x_reg;
    assign m_cursor_y    = out_y_reg;
    assign m_moved       = out_moved_reg;
    assign m_left_button = out_left_reg;
    assign m_icon_hit    = out_hit_reg;

endmodule
